FILE: sv/assert_macros.svh
// assertion macros shared by the block change map rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define BCM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// consequence checked in the cycle after the trigger
`define BCM_ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) trig |=> cons) \
		else $error(msg);

`endif

FILE: sv/bcm_pkg.sv
// types and constants of the block change map
package bcm_pkg;

	localparam int PIXEL_W          = 32;
	localparam int CFG_W            = 13;
	localparam int CFG_IDX_W        = 2;
	localparam int EIGHTHS_W        = 6;
	localparam int TILE_IDX_W       = 9;
	localparam int TILE_OFS_W       = 8;
	localparam int LINE_W           = 12;
	localparam int LINE_LIMIT       = 4096;
	localparam int EIGHTHS_LIMIT    = 32;

	localparam int MAX_FRAME_WIDTH  = 4096;
	localparam int MAX_TILE_COLUMNS = 512;

	localparam logic [CFG_W-1:0]     FRAME_WIDTH_RST  = 13'd1920;
	localparam logic [CFG_W-1:0]     FRAME_HEIGHT_RST = 13'd1080;
	localparam logic [EIGHTHS_W-1:0] TILE_EIGHTHS_RST = 6'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH   = 2'd0,
		CFG_FRAME_HEIGHT  = 2'd1,
		CFG_TILE_W_EIGHTH = 2'd2,
		CFG_TILE_H_EIGHTH = 2'd3
	} cfg_idx_t;

	// position flags of the item at the head of the raster
	typedef struct packed {
		logic line_end;
		logic last_line;
		logic tile_done;
		logic frame_done;
		logic row_clear;
	} raster_flags_t;

	// clamp an eighths register to 1..32 and give tile size minus one
	function automatic logic [TILE_OFS_W-1:0] tile_size_m1(input logic [EIGHTHS_W-1:0] e);
		logic [EIGHTHS_W-1:0] ec;
		logic [EIGHTHS_W+2:0] px;
		begin
			if (e == '0) begin
				ec = EIGHTHS_W'(1);
			end else if (32'(e) > 32'(EIGHTHS_LIMIT)) begin
				ec = EIGHTHS_W'(EIGHTHS_LIMIT);
			end else begin
				ec = e;
			end
			px = {ec, 3'b000} - (EIGHTHS_W+3)'(1);
			return TILE_OFS_W'(px);
		end
	endfunction

endpackage

FILE: sv/bcm_pixel_if.sv
// pixel pair channel
interface bcm_pixel_if;
	logic                          valid;
	logic                          ready;
	logic [bcm_pkg::PIXEL_W-1:0]   current_pixel;
	logic [bcm_pkg::PIXEL_W-1:0]   previous_pixel;

	modport source (output valid, current_pixel, previous_pixel, input ready);
	modport sink (input valid, current_pixel, previous_pixel, output ready);
endinterface

FILE: sv/bcm_tile_if.sv
// finished tile channel
interface bcm_tile_if;
	logic                           valid;
	logic                           ready;
	logic [bcm_pkg::TILE_IDX_W-1:0] tile_column;
	logic [bcm_pkg::TILE_IDX_W-1:0] tile_row;
	logic                           changed;
	logic                           frame_end;

	modport source (output valid, tile_column, tile_row, changed, frame_end, input ready);
	modport sink (input valid, tile_column, tile_row, changed, frame_end, output ready);
endinterface

FILE: sv/bcm_cfg_if.sv
// configuration write channel
interface bcm_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [bcm_pkg::CFG_IDX_W-1:0] index;
	logic [bcm_pkg::CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/bcm_ram.sv
// generic single write port ram with registered read
module bcm_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 512
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/bcm_raster.sv
// raster position, tile position and end-of-tile decode
`include "assert_macros.svh"

module bcm_raster #(
	parameter int MAX_FRAME_WIDTH = bcm_pkg::MAX_FRAME_WIDTH
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   step,
	input  logic [bcm_pkg::CFG_W-1:0]              frame_width,
	input  logic [bcm_pkg::CFG_W-1:0]              frame_height,
	input  logic [bcm_pkg::EIGHTHS_W-1:0]          tile_width_eighths,
	input  logic [bcm_pkg::EIGHTHS_W-1:0]          tile_height_eighths,
	output bcm_pkg::raster_flags_t                 flags,
	output logic [$clog2(MAX_FRAME_WIDTH)-1:0]     col,
	output logic [$clog2(MAX_FRAME_WIDTH)-1:0]     col_next,
	output logic [bcm_pkg::LINE_W-1:0]             row
);

	localparam int PxW = $clog2(MAX_FRAME_WIDTH);

	logic [PxW-1:0]                    px_q;
	logic [PxW-1:0]                    col_q;
	logic [bcm_pkg::LINE_W-1:0]        py_q;
	logic [bcm_pkg::LINE_W-1:0]        row_q;
	logic [bcm_pkg::TILE_OFS_W-1:0]    xt_q;
	logic [bcm_pkg::TILE_OFS_W-1:0]    yt_q;

	logic [PxW-1:0]                    w_m1;
	logic [bcm_pkg::LINE_W-1:0]        h_m1;
	logic [bcm_pkg::TILE_OFS_W-1:0]    tw_m1;
	logic [bcm_pkg::TILE_OFS_W-1:0]    th_m1;
	logic                              line_end;
	logic                              last_line;
	logic                              tile_x_end;
	logic                              tile_y_end;

	always_comb begin
		if (frame_width == '0) begin
			w_m1 = '0;
		end else if (32'(frame_width) > 32'(MAX_FRAME_WIDTH)) begin
			w_m1 = PxW'(MAX_FRAME_WIDTH - 1);
		end else begin
			w_m1 = PxW'(frame_width - bcm_pkg::CFG_W'(1));
		end
		if (frame_height == '0) begin
			h_m1 = '0;
		end else if (32'(frame_height) > 32'(bcm_pkg::LINE_LIMIT)) begin
			h_m1 = bcm_pkg::LINE_W'(bcm_pkg::LINE_LIMIT - 1);
		end else begin
			h_m1 = bcm_pkg::LINE_W'(frame_height - bcm_pkg::CFG_W'(1));
		end
		tw_m1 = bcm_pkg::tile_size_m1(tile_width_eighths);
		th_m1 = bcm_pkg::tile_size_m1(tile_height_eighths);
	end

	// a position at or past an end counts as that end
	assign line_end   = px_q >= w_m1;
	assign last_line  = py_q >= h_m1;
	assign tile_x_end = line_end || (xt_q >= tw_m1);
	assign tile_y_end = last_line || (yt_q >= th_m1);

	assign flags.line_end   = line_end;
	assign flags.last_line  = last_line;
	assign flags.tile_done  = tile_x_end && tile_y_end;
	assign flags.frame_done = line_end && last_line;
	assign flags.row_clear  = line_end && (last_line || tile_y_end);

	assign col      = col_q;
	assign row      = row_q;
	assign col_next = line_end ? '0 : (tile_x_end ? col_q + PxW'(1) : col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q  <= '0;
			py_q  <= '0;
			xt_q  <= '0;
			yt_q  <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			col_q <= col_next;
			if (!line_end) begin
				px_q <= px_q + PxW'(1);
				xt_q <= tile_x_end ? '0 : xt_q + bcm_pkg::TILE_OFS_W'(1);
			end else begin
				px_q <= '0;
				xt_q <= '0;
				if (last_line) begin
					py_q  <= '0;
					yt_q  <= '0;
					row_q <= '0;
				end else begin
					py_q <= py_q + bcm_pkg::LINE_W'(1);
					if (tile_y_end) begin
						yt_q  <= '0;
						row_q <= row_q + bcm_pkg::LINE_W'(1);
					end else begin
						yt_q <= yt_q + bcm_pkg::TILE_OFS_W'(1);
					end
				end
			end
		end
	end

	`BCM_ASSERT(a_col_origin, (px_q == '0) |-> (col_q == '0), "tile column not zero at line start")

endmodule

FILE: sv/block_change_map.sv
// block change map: a tile result is loaded into the result register when its last pixel item leaves the stage register
// throughput one pixel item per cycle unless a held tile result stalls it; a single pass from stage to result register
// the per-column flag ram is read one item ahead, so its registered read never stalls the stream
// reset returns the configuration registers to their defaults and zeroes all position counters
// the flag ram is not swept: a fill count marks the columns written since the last row clear
module block_change_map #(
	parameter int MAX_FRAME_WIDTH  = bcm_pkg::MAX_FRAME_WIDTH,
	parameter int MAX_TILE_COLUMNS = bcm_pkg::MAX_TILE_COLUMNS
) (
	input  logic        clk,
	input  logic        arst_n,
	bcm_pixel_if.sink   pix,
	bcm_tile_if.source  tile,
	bcm_cfg_if.sink     cfg
);

	`include "assert_macros.svh"

	localparam int PxW     = $clog2(MAX_FRAME_WIDTH);
	localparam int SlotW   = (MAX_TILE_COLUMNS > 1) ? $clog2(MAX_TILE_COLUMNS) : 1;
	localparam int FillW   = $clog2(MAX_TILE_COLUMNS + 1);
	localparam int ColExtW = (PxW > bcm_pkg::TILE_IDX_W) ? PxW : bcm_pkg::TILE_IDX_W;
	localparam int RowExtW = (bcm_pkg::LINE_W > bcm_pkg::TILE_IDX_W) ?
		bcm_pkg::LINE_W : bcm_pkg::TILE_IDX_W;

	// configuration registers
	logic [bcm_pkg::CFG_W-1:0]     frame_width_q;
	logic [bcm_pkg::CFG_W-1:0]     frame_height_q;
	logic [bcm_pkg::EIGHTHS_W-1:0] tile_w_eighths_q;
	logic [bcm_pkg::EIGHTHS_W-1:0] tile_h_eighths_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q    <= bcm_pkg::FRAME_WIDTH_RST;
			frame_height_q   <= bcm_pkg::FRAME_HEIGHT_RST;
			tile_w_eighths_q <= bcm_pkg::TILE_EIGHTHS_RST;
			tile_h_eighths_q <= bcm_pkg::TILE_EIGHTHS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				bcm_pkg::CFG_FRAME_WIDTH:   frame_width_q    <= cfg.data;
				bcm_pkg::CFG_FRAME_HEIGHT:  frame_height_q   <= cfg.data;
				bcm_pkg::CFG_TILE_W_EIGHTH: tile_w_eighths_q <= bcm_pkg::EIGHTHS_W'(cfg.data);
				bcm_pkg::CFG_TILE_H_EIGHTH: tile_h_eighths_q <= bcm_pkg::EIGHTHS_W'(cfg.data);
				default: ;
			endcase
		end
	end

	// stage 1: compare result of the accepted item
	logic valid_s1;
	logic diff_s1;
	logic advance;

	// result register
	logic                           out_valid_q;
	logic [bcm_pkg::TILE_IDX_W-1:0] tile_column_q;
	logic [bcm_pkg::TILE_IDX_W-1:0] tile_row_q;
	logic                           changed_q;
	logic                           frame_end_q;

	bcm_pkg::raster_flags_t     flags;
	logic [PxW-1:0]             col;
	logic [PxW-1:0]             col_next;
	logic [bcm_pkg::LINE_W-1:0] row;

	bcm_raster #(
		.MAX_FRAME_WIDTH (MAX_FRAME_WIDTH)
	) u_raster (
		.clk                 (clk),
		.arst_n              (arst_n),
		.step                (advance),
		.frame_width         (frame_width_q),
		.frame_height        (frame_height_q),
		.tile_width_eighths  (tile_w_eighths_q),
		.tile_height_eighths (tile_h_eighths_q),
		.flags               (flags),
		.col                 (col),
		.col_next            (col_next),
		.row                 (row)
	);

	assign advance   = valid_s1 && (!flags.tile_done || !out_valid_q || tile.ready);
	assign pix.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix.valid && pix.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix.valid && pix.ready) begin
			diff_s1 <= pix.current_pixel != pix.previous_pixel;
		end
	end

	// flag store: columns past the store share its last entry
	logic [SlotW-1:0] slot_cur;
	logic [SlotW-1:0] slot_nxt;
	logic [FillW-1:0] fill_q;
	logic [FillW-1:0] fill_wr;
	logic             use_mem_q;
	logic             byp_q;
	logic             ram_rdata;
	logic             flag_prior;
	logic             flag_now;
	logic             rd_mem;
	logic             next_use_mem;
	logic             next_byp;

	assign slot_cur = SlotW'((32'(col) > 32'(MAX_TILE_COLUMNS - 1)) ?
		32'(MAX_TILE_COLUMNS - 1) : 32'(col));
	assign slot_nxt = SlotW'((32'(col_next) > 32'(MAX_TILE_COLUMNS - 1)) ?
		32'(MAX_TILE_COLUMNS - 1) : 32'(col_next));

	assign flag_prior = use_mem_q ? ram_rdata : byp_q;
	assign flag_now   = flag_prior | diff_s1;

	// written columns since a clear always run from zero upwards
	assign fill_wr = ((32'(slot_cur) + 32'd1) > 32'(fill_q)) ?
		FillW'(32'(slot_cur) + 32'd1) : fill_q;

	always_comb begin
		rd_mem       = 1'b0;
		next_use_mem = 1'b0;
		next_byp     = 1'b0;
		if (flags.row_clear) begin
			next_byp = 1'b0;
		end else if (slot_nxt == slot_cur) begin
			next_byp = flag_now;
		end else if (32'(slot_nxt) < 32'(fill_wr)) begin
			rd_mem       = 1'b1;
			next_use_mem = 1'b1;
		end
	end

	bcm_ram #(
		.WIDTH (1),
		.DEPTH (MAX_TILE_COLUMNS)
	) u_flag_ram (
		.clk   (clk),
		.we    (advance),
		.waddr (slot_cur),
		.wdata (flag_now),
		.re    (advance && rd_mem),
		.raddr (slot_nxt),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			use_mem_q <= 1'b0;
			byp_q     <= 1'b0;
		end else if (advance) begin
			fill_q    <= flags.row_clear ? '0 : fill_wr;
			use_mem_q <= next_use_mem;
			byp_q     <= next_byp;
		end
	end

	// result register
	logic [ColExtW-1:0] col_ext;
	logic [RowExtW-1:0] row_ext;

	assign col_ext = ColExtW'(col);
	assign row_ext = RowExtW'(row);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && flags.tile_done) begin
			out_valid_q <= 1'b1;
		end else if (tile.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && flags.tile_done) begin
			tile_column_q <= col_ext[bcm_pkg::TILE_IDX_W-1:0];
			tile_row_q    <= row_ext[bcm_pkg::TILE_IDX_W-1:0];
			changed_q     <= flag_now;
			frame_end_q   <= flags.frame_done;
		end
	end

	assign tile.valid       = out_valid_q;
	assign tile.tile_column = tile_column_q;
	assign tile.tile_row    = tile_row_q;
	assign tile.changed     = changed_q;
	assign tile.frame_end   = frame_end_q;

	`BCM_ASSERT_NEXT(a_row_clear, advance && flags.row_clear, (fill_q == '0) && !use_mem_q && !byp_q, "flag state not cleared at new tile row")
	`BCM_ASSERT(a_mem_written, use_mem_q |-> (32'(slot_cur) < 32'(fill_q)), "flag read from a column not written since clear")
	`BCM_ASSERT_NEXT(a_result_loaded, advance && flags.tile_done, out_valid_q, "finished tile not presented")
	`BCM_ASSERT(a_frame_end_tile, (advance && flags.frame_done) |-> flags.tile_done, "frame end off a tile boundary")

endmodule
